// File: hw/rtl/dtem_pkg.sv
// shared types, constants and lookup functions for the date/time to epoch ms pipeline
// used by every module of the block but dtem_checker; depends on nothing

package dtem_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int MS_W    = 16;
  localparam int EPOCH_W = 49;
  localparam int TDATA_IN_W  = 56;
  localparam int TDATA_OUT_W = 56;

  // internal widths
  localparam int T_W     = 15;   // year plus offset
  localparam int Q_W     = 6;    // 400-year cycle index plus bias
  localparam int R400_W  = 9;    // year within the 400-year cycle
  localparam int DOY_W   = 9;    // day within the year
  localparam int DAYS_W  = 23;   // signed day count
  localparam int TOD_W   = 27;   // milliseconds within the day
  localparam int PROD_W  = 30;

  // validity limits
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [HOUR_W-1:0]  HOURS_LIM   = 5'd24;
  localparam logic [MIN_W-1:0]   MINUTES_LIM = 6'd60;
  localparam logic [MS_W-1:0]    MS_LIM      = 16'd60000;

  // year shift: year + 430 = (year - 1970) + 6 * 400, never negative
  localparam logic [T_W-1:0]    YEAR_OFFSET = 15'd430;
  localparam logic [Q_W-1:0]    CYCLE_BIAS  = 6'd6;
  // floor(t / 400) = (t * 41944) >> 24, exact for t below 2^15
  localparam logic [PROD_W-1:0] RECIP_400   = 30'd41944;
  localparam int                RECIP_SHIFT = 24;
  localparam logic [T_W-1:0]    YEARS_400   = 15'd400;

  // century years inside a cycle counted from 1970
  localparam logic [R400_W-1:0] CENT_A      = 9'd130;
  localparam logic [R400_W-1:0] CENT_B      = 9'd230;
  localparam logic [R400_W-1:0] CENT_C      = 9'd330;

  localparam logic [DAYS_W-1:0] DAYS_400Y   = 23'd146097;
  localparam logic [DAYS_W-1:0] DAYS_4Y     = 23'd1461;
  localparam logic [DAYS_W-1:0] DAYS_1Y     = 23'd365;

  localparam logic [TOD_W-1:0]  MS_PER_HOUR = 27'd3600000;
  localparam logic [TOD_W-1:0]  MS_PER_MIN  = 27'd60000;
  localparam logic signed [27:0] MS_PER_DAY = 28'sd86400000;

  // one input request
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hours;
    logic [MIN_W-1:0]   minutes;
    logic [MS_W-1:0]    seconds_ms;
  } req_t;

  // after the range checks and the 400-year division
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hours;
    logic [MIN_W-1:0]   minutes;
    logic [MS_W-1:0]    seconds_ms;
    logic [Q_W-1:0]     q;
    logic               ok;
  } s1_t;

  // cycle split, day of year and time of day
  typedef struct packed {
    logic [R400_W-1:0] r400;
    logic [Q_W-1:0]    p400;
    logic [DOY_W-1:0]  doy;
    logic              past_feb;
    logic              ok;
    logic [TOD_W-1:0]  tod;
  } s2_t;

  // signed day count since the epoch
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic              ok;
    logic [TOD_W-1:0]  tod;
  } s3_t;

  // day count scaled to milliseconds
  typedef struct packed {
    logic [EPOCH_W-1:0] prod;
    logic               ok;
    logic [TOD_W-1:0]   tod;
  } s4_t;

  // one result
  typedef struct packed {
    logic               valid_res;
    logic [EPOCH_W-1:0] epoch_ms;
  } res_t;

  // days in the year before the first of the month
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // length of the month, leap February included
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:    n = leap ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/dtem_check.sv
// first two pipeline stages: range checks, 400-year division, day of year, time of day
// depends on dtem_pkg

module dtem_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtem_pkg::req_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output dtem_pkg::s2_t   out_item
);

  logic            v1;
  dtem_pkg::s1_t   s1;
  dtem_pkg::s1_t   s1_next;
  logic            ready1;
  logic            ready2;
  logic [dtem_pkg::T_W-1:0]    t1;
  logic [dtem_pkg::PROD_W-1:0] prod1;

  logic [dtem_pkg::T_W-1:0]    t2;
  logic [dtem_pkg::T_W-1:0]    q400;
  logic [dtem_pkg::T_W-1:0]    diff;
  logic [dtem_pkg::R400_W-1:0] r400;
  logic                        leap;
  logic                        past_feb;
  logic                        bump;
  dtem_pkg::s2_t               s2_next;

  // stage handshake: a stage loads when it is empty or its content moves on
  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // stage 1: range checks and reciprocal multiply for floor(t / 400)
  assign t1    = {1'b0, in_item.year} + dtem_pkg::YEAR_OFFSET;
  assign prod1 = dtem_pkg::PROD_W'(t1) * dtem_pkg::RECIP_400;

  always_comb begin
    s1_next.year       = in_item.year;
    s1_next.month      = in_item.month;
    s1_next.day        = in_item.day;
    s1_next.hours      = in_item.hours;
    s1_next.minutes    = in_item.minutes;
    s1_next.seconds_ms = in_item.seconds_ms;
    s1_next.q          = prod1[dtem_pkg::RECIP_SHIFT +: dtem_pkg::Q_W];
    s1_next.ok         = (in_item.year != '0) && (in_item.year <= dtem_pkg::YEAR_MAX) &&
                         (in_item.month >= dtem_pkg::MONTH_FIRST) &&
                         (in_item.month <= dtem_pkg::MONTH_LAST) &&
                         (in_item.day != '0) &&
                         (in_item.hours < dtem_pkg::HOURS_LIM) &&
                         (in_item.minutes < dtem_pkg::MINUTES_LIM) &&
                         (in_item.seconds_ms < dtem_pkg::MS_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1 <= s1_next;
    end
  end

  // stage 2: remainder in the cycle, leap test, month length, day of year, time of day
  assign t2       = {1'b0, s1.year} + dtem_pkg::YEAR_OFFSET;
  assign q400     = dtem_pkg::T_W'(s1.q) * dtem_pkg::YEARS_400;
  assign diff     = t2 - q400;
  assign r400     = diff[dtem_pkg::R400_W-1:0];
  // year divisible by 4 and not a plain century (centuries land on 130, 230, 330)
  assign leap     = (s1.year[1:0] == 2'b00) && (r400 != dtem_pkg::CENT_A) &&
                    (r400 != dtem_pkg::CENT_B) && (r400 != dtem_pkg::CENT_C);
  assign past_feb = s1.month > dtem_pkg::MONTH_FEB;
  // third year of each 4-year group counted from 1970 is the leap one
  assign bump     = (r400[1:0] == 2'd2) && past_feb;

  always_comb begin
    s2_next.r400     = r400;
    s2_next.p400     = s1.q - dtem_pkg::CYCLE_BIAS;
    s2_next.doy      = dtem_pkg::DOY_W'(s1.day) - dtem_pkg::DOY_W'(1) +
                       dtem_pkg::days_before(s1.month) + dtem_pkg::DOY_W'(bump);
    s2_next.past_feb = past_feb;
    s2_next.ok       = s1.ok && (s1.day <= dtem_pkg::month_len(s1.month, leap));
    s2_next.tod      = dtem_pkg::TOD_W'(s1.hours) * dtem_pkg::MS_PER_HOUR +
                       dtem_pkg::TOD_W'(s1.minutes) * dtem_pkg::MS_PER_MIN +
                       dtem_pkg::TOD_W'(s1.seconds_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      out_item <= s2_next;
    end
  end

endmodule

// File: hw/rtl/dtem_days.sv
// third pipeline stage: assembles the signed day count from cycles, years and corrections
// depends on dtem_pkg

module dtem_days (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtem_pkg::s2_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output dtem_pkg::s3_t  out_item
);

  logic [dtem_pkg::DAYS_W-1:0] p_ext;
  logic [1:0]                  r4;
  logic                        c_a;
  logic                        c_b;
  logic                        c_c;
  dtem_pkg::s3_t               s3_next;

  assign in_ready = !out_valid || out_ready;

  // century corrections once past February 29 of a skipped century
  assign r4    = in_item.r400[1:0];
  assign c_a   = (in_item.r400 > dtem_pkg::CENT_A) ||
                 ((in_item.r400 == dtem_pkg::CENT_A) && in_item.past_feb);
  assign c_b   = (in_item.r400 > dtem_pkg::CENT_B) ||
                 ((in_item.r400 == dtem_pkg::CENT_B) && in_item.past_feb);
  assign c_c   = (in_item.r400 > dtem_pkg::CENT_C) ||
                 ((in_item.r400 == dtem_pkg::CENT_C) && in_item.past_feb);
  assign p_ext = {{(dtem_pkg::DAYS_W-dtem_pkg::Q_W){in_item.p400[dtem_pkg::Q_W-1]}},
                  in_item.p400};

  // two's complement sum, wraps only for requests that fail the checks
  always_comb begin
    s3_next.days = p_ext * dtem_pkg::DAYS_400Y +
                   dtem_pkg::DAYS_W'(in_item.r400[dtem_pkg::R400_W-1:2]) * dtem_pkg::DAYS_4Y +
                   dtem_pkg::DAYS_W'(r4) * dtem_pkg::DAYS_1Y +
                   dtem_pkg::DAYS_W'(r4 == 2'd3) +
                   dtem_pkg::DAYS_W'(in_item.doy) -
                   dtem_pkg::DAYS_W'(c_a) - dtem_pkg::DAYS_W'(c_b) - dtem_pkg::DAYS_W'(c_c);
    s3_next.ok   = in_item.ok;
    s3_next.tod  = in_item.tod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= s3_next;
    end
  end

endmodule

// File: hw/rtl/dtem_scale.sv
// last two pipeline stages: day count times ms per day, then time of day added and gated
// depends on dtem_pkg

module dtem_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtem_pkg::s3_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output dtem_pkg::res_t out_item
);

  logic                               v4;
  dtem_pkg::s4_t                      s4;
  dtem_pkg::s4_t                      s4_next;
  logic                               ready4;
  logic                               ready5;
  logic signed [dtem_pkg::EPOCH_W+1:0] mul;
  logic [dtem_pkg::EPOCH_W-1:0]       sum;
  dtem_pkg::res_t                     res_next;

  assign ready5   = !out_valid || out_ready;
  assign ready4   = !v4 || ready5;
  assign in_ready = ready4;

  // stage 4: signed 23 x 28 multiply
  assign mul = $signed(in_item.days) * dtem_pkg::MS_PER_DAY;

  always_comb begin
    s4_next.prod = mul[dtem_pkg::EPOCH_W-1:0];
    s4_next.ok   = in_item.ok;
    s4_next.tod  = in_item.tod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && in_valid) begin
      s4 <= s4_next;
    end
  end

  // stage 5: add time of day, zero count for rejected requests
  assign sum = s4.prod + dtem_pkg::EPOCH_W'(s4.tod);

  always_comb begin
    res_next.valid_res = s4.ok;
    res_next.epoch_ms  = s4.ok ? sum : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      out_item <= res_next;
    end
  end

endmodule

// File: hw/rtl/date_time_to_epoch_ms_top.sv
// top level: calendar date and time of day to signed milliseconds since 1970-01-01
// depends on dtem_pkg, dtem_check, dtem_days, dtem_scale
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------------
//   s_*      | in        | tdata: year, month, day, hours, minutes, seconds_ms
//   m_*      | out       | tuser: valid_res; tdata: epoch_ms
//
// one request per cycle sustained when the output side is not stalled; five register
// stages: stages 1 and 2 in dtem_check, 3 in dtem_days, 4 and 5 in dtem_scale
// the slowest stage is the signed day count times ms-per-day multiplier
// rst is synchronous and clears only the stage valid bits
// each stage loads whenever it is empty or its content moves on, so bubbles close up
// and s_tready stays high while any stage is free, even with a result held at m_*

module date_time_to_epoch_ms_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // year[13:0], month[17:14], day[22:18], hours[27:23],
                                 // minutes[33:28], seconds_ms[49:34], zero pad above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // epoch_ms[48:0] two's complement, zero pad above
  output logic [0:0]  m_tuser    // valid_res[0]
);

  dtem_pkg::req_t  req;
  dtem_pkg::s2_t   s2;
  dtem_pkg::s3_t   s3;
  dtem_pkg::res_t  res;
  logic            v2;
  logic            v3;
  logic            r2;
  logic            r3;

  // unpack the request
  assign req.year       = s_tdata[13:0];
  assign req.month      = s_tdata[17:14];
  assign req.day        = s_tdata[22:18];
  assign req.hours      = s_tdata[27:23];
  assign req.minutes    = s_tdata[33:28];
  assign req.seconds_ms = s_tdata[49:34];

  dtem_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (req),
    .out_valid (v2),
    .out_ready (r2),
    .out_item  (s2)
  );

  dtem_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_item   (s2),
    .out_valid (v3),
    .out_ready (r3),
    .out_item  (s3)
  );

  dtem_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (r3),
    .in_item   (s3),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res)
  );

  // pack the result
  assign m_tdata = {{(dtem_pkg::TDATA_OUT_W-dtem_pkg::EPOCH_W){1'b0}}, res.epoch_ms};
  assign m_tuser = res.valid_res;

endmodule

// File: hw/rtl/dtem_checker.sv
// port-level checks for the date/time to epoch ms block, attached by bind
// depends on date_time_to_epoch_ms_top

module dtem_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic [0:0]  m_tuser
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a rejected request gives a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 56'd0)
    else $error("nonzero count on invalid result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

  // with no result waiting the pipeline has room for a request
  a_room: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

endmodule

bind date_time_to_epoch_ms_top dtem_checker u_dtem_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
